// ===== rtl/cfb_pkg.sv =====
// Shared types and constants for the command frame builder.
`timescale 1ns / 1ps

package cfb_pkg;

	// Command word action codes
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_DATA  = 1'b1;

	// Configuration register indexes
	localparam int         CFG_IDX_W    = 1;
	localparam logic [0:0] REG_CRC_SEED = 1'b0;
	localparam logic [0:0] REG_CRC_POLY = 1'b1;

	localparam logic [15:0] CRC_SEED_RST  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY_RST  = 16'hA001;
	localparam logic [15:0] CRC_VALUE_RST = 16'hFFFF;

	// Frame header bytes
	localparam logic [7:0] HDR0 = 8'hFF;
	localparam logic [7:0] HDR1 = 8'hAA;
	localparam logic [7:0] HDR2 = 8'h7F;

	// Byte position within the output run of one command word
	localparam int IDX_W = 3;
	// start word
	localparam logic [IDX_W-1:0] P_HDR0   = 3'd0;
	localparam logic [IDX_W-1:0] P_HDR1   = 3'd1;
	localparam logic [IDX_W-1:0] P_HDR2   = 3'd2;
	localparam logic [IDX_W-1:0] P_CODE   = 3'd3;
	localparam logic [IDX_W-1:0] P_LENLO  = 3'd4;
	localparam logic [IDX_W-1:0] P_LENHI  = 3'd5;
	localparam logic [IDX_W-1:0] P_SCRCLO = 3'd6;
	localparam logic [IDX_W-1:0] P_SCRCHI = 3'd7;
	// payload word
	localparam logic [IDX_W-1:0] P_DATA   = 3'd0;
	localparam logic [IDX_W-1:0] P_PCRCLO = 3'd1;
	localparam logic [IDX_W-1:0] P_PCRCHI = 3'd2;

	typedef struct packed {
		logic        action;
		logic [7:0]  frame_code;
		logic [15:0] frame_length;
		logic [7:0]  data_byte;
		logic        final_flag;
	} cmd_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       end_of_frame;
		logic       end_of_run;
	} frm_t;

endpackage

// ===== rtl/cfb_crc_byte.sv =====
// One-byte update of a reflected CRC-16 with programmable polynomial.
`timescale 1ns / 1ps

module cfb_crc_byte (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	input  logic [15:0] poly,
	output logic [15:0] crc_out
);
	import cfb_pkg::*;

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ poly;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

// ===== rtl/command_frame_builder_crc16.sv =====
// Command frame builder: header, payload and CRC-16 trailer, one payload byte per word.
//
//  channel | valid     | stall     | word
//  --------+-----------+-----------+---------------------------
//  command | cmd_valid | cmd_stall | cmd_word (cfb_pkg::cmd_t)
//  frame   | frm_valid | frm_stall | frm_word (cfb_pkg::frm_t)
//  config  | cfg_we    | -         | cfg_index, cfg_data
//
// A start word gives 6 bytes (8 with final_flag), a payload word 1 (3 with final_flag);
// frm_word moves one byte per cycle unless stalled; a word holds the input to its last byte.
// The next command word is taken in the cycle its predecessor's last byte is loaded.
// The CRC takes in each loaded non-CRC byte; output passes the held-word and output register.
// Reset clears the held-word and output valid flags, the frame-open flag and the registers.
// frm_stall freezes a valid output word; the command side stalls until a held word is done.
`timescale 1ns / 1ps

module command_frame_builder_crc16 (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_stall,
	input  cfb_pkg::cmd_t                cmd_word,
	output logic                         frm_valid,
	input  logic                         frm_stall,
	output cfb_pkg::frm_t                frm_word,
	input  logic                         cfg_we,
	input  logic [cfb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                  cfg_data
);
	import cfb_pkg::*;

	logic [15:0]      seed_q, poly_q, crc_q;
	logic             open_q;
	cmd_t             item_q;
	logic             item_vld_q;
	logic [IDX_W-1:0] idx_q;
	frm_t             frm_q;
	logic             frm_vld_q;

	logic             is_start, is_data, is_eof, is_last;
	logic [IDX_W-1:0] last_idx;
	logic [7:0]       byte_sel;
	logic [15:0]      crc_base, crc_next;
	logic             out_ld, done, cmd_acc, keep;

	always_comb begin
		is_start = (item_q.action == ACT_START);
		byte_sel = crc_q[7:0];
		is_data  = 1'b0;
		is_eof   = 1'b0;
		if (is_start) begin
			last_idx = item_q.final_flag ? P_SCRCHI : P_LENHI;
			case (idx_q)
				P_HDR0:   begin byte_sel = HDR0;                      is_data = 1'b1; end
				P_HDR1:   begin byte_sel = HDR1;                      is_data = 1'b1; end
				P_HDR2:   begin byte_sel = HDR2;                      is_data = 1'b1; end
				P_CODE:   begin byte_sel = item_q.frame_code;         is_data = 1'b1; end
				P_LENLO:  begin byte_sel = item_q.frame_length[7:0];  is_data = 1'b1; end
				P_LENHI:  begin byte_sel = item_q.frame_length[15:8]; is_data = 1'b1; end
				P_SCRCLO: byte_sel = crc_q[7:0];
				P_SCRCHI: begin byte_sel = crc_q[15:8]; is_eof = 1'b1; end
				default:  byte_sel = crc_q[7:0];
			endcase
		end else begin
			last_idx = item_q.final_flag ? P_PCRCHI : P_DATA;
			case (idx_q)
				P_DATA:   begin byte_sel = item_q.data_byte; is_data = 1'b1; end
				P_PCRCLO: byte_sel = crc_q[7:0];
				P_PCRCHI: begin byte_sel = crc_q[15:8]; is_eof = 1'b1; end
				default:  byte_sel = crc_q[7:0];
			endcase
		end
		is_last = (idx_q == last_idx);
	end

	// first header byte starts from the seed
	assign crc_base = (is_start && idx_q == P_HDR0) ? seed_q : crc_q;

	cfb_crc_byte u_crc (
		.crc_in  (crc_base),
		.data    (byte_sel),
		.poly    (poly_q),
		.crc_out (crc_next)
	);

	assign out_ld    = item_vld_q && (!frm_vld_q || !frm_stall);
	assign done      = out_ld && is_last;
	assign cmd_stall = item_vld_q && !done;
	assign cmd_acc   = cmd_valid && !cmd_stall;
	// payload outside a frame is dropped at the door
	assign keep      = (cmd_word.action == ACT_START) || open_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q     <= CRC_SEED_RST;
			poly_q     <= CRC_POLY_RST;
			crc_q      <= CRC_VALUE_RST;
			open_q     <= 1'b0;
			item_vld_q <= 1'b0;
			idx_q      <= '0;
			frm_vld_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CRC_SEED: seed_q <= cfg_data;
					REG_CRC_POLY: poly_q <= cfg_data;
					default:      seed_q <= seed_q;
				endcase
			end

			if (cmd_acc) begin
				if (cmd_word.action == ACT_START || open_q) begin
					open_q <= !cmd_word.final_flag;
				end
			end

			if (out_ld) begin
				if (is_data) begin
					crc_q <= crc_next;
				end
				idx_q <= is_last ? '0 : idx_q + 1'b1;
			end

			if (cmd_acc) begin
				item_vld_q <= keep;
			end else if (done) begin
				item_vld_q <= 1'b0;
			end

			if (out_ld) begin
				frm_vld_q <= 1'b1;
			end else if (!frm_stall) begin
				frm_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			item_q <= cmd_word;
		end
		if (out_ld) begin
			frm_q.out_byte     <= byte_sel;
			frm_q.end_of_frame <= is_eof;
			frm_q.end_of_run   <= is_last;
		end
	end

	assign frm_valid = frm_vld_q;
	assign frm_word  = frm_q;

endmodule

// ===== rtl/cfb_checker.sv =====
// Port-level assertions for the command frame builder, bound to the top level.
`timescale 1ns / 1ps

module cfb_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_stall,
	input cfb_pkg::cmd_t cmd_word,
	input logic          frm_valid,
	input logic          frm_stall,
	input cfb_pkg::frm_t frm_word
);
	import cfb_pkg::*;

	// a stalled output word holds
	a_frm_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frm_valid && frm_stall |=> frm_valid && $stable(frm_word))
		else $error("frame word changed while stalled");

	// the closing CRC byte always ends the run of its command word
	a_eof_eor: assert property (@(posedge clk) disable iff (!arst_n)
		frm_valid && frm_word.end_of_frame |-> frm_word.end_of_run)
		else $error("end_of_frame without end_of_run");

	// an accepted start word always leads to frm_valid through the held-word and output registers
	a_start_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && cmd_word.action == ACT_START |-> ##2 frm_valid)
		else $error("start word produced no output");

	// a held word never waits behind an empty output register
	a_stall_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall && !frm_valid |=> frm_valid)
		else $error("held command word did not load output");

endmodule

bind command_frame_builder_crc16 cfb_checker u_cfb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd_word  (cmd_word),
	.frm_valid (frm_valid),
	.frm_stall (frm_stall),
	.frm_word  (frm_word)
);
